FILE: src/cld_pkg.sv
`default_nettype none

package cld_pkg;

    localparam int MAX_BODY_W   = 27;
    localparam int MAX_HEADER_W = 17;
    localparam int CFG_DATA_W   = 27;
    localparam int PREFIX_LEN   = 15;

    localparam logic [MAX_BODY_W-1:0]   MAX_BODY_RESET   = 27'd67108864;
    localparam logic [MAX_HEADER_W-1:0] MAX_HEADER_RESET = 17'd65536;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic {
        REG_MAX_BODY   = 1'b0,
        REG_MAX_HEADER = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_HEADER_LONG = 2'd0,
        ERR_INVALID     = 2'd1,
        ERR_MISSING     = 2'd2,
        ERR_TOO_LARGE   = 2'd3
    } err_t;

    typedef enum logic [3:0] {
        PH_PREFIX = 4'b0001,
        PH_SPACE  = 4'b0010,
        PH_DIGIT  = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    // "Content-Length:"
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43;
            4'd1:    ch = 8'h6f;
            4'd2:    ch = 8'h6e;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6e;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2d;
            4'd8:    ch = 8'h4c;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6e;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            4'd14:   ch = 8'h3a;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: src/content_length_deframer.sv
`default_nettype none

// Content-Length deframer: takes one stream byte per cycle on s_ while the output is not stalled
// and, once a header ending in CR LF CR LF has carried a valid Content-Length line, passes that
// many body bytes out on m_ with m_last on the final one (a zero length gives one empty-message
// word, a bad header one error word). The result word of an accepted byte, if any, sits in the
// output register in the cycle after it is accepted; s_ready is high whenever that register is
// empty or being taken, so a stalled output holds the input for exactly as long as the stall
// lasts. The header state lives in a handful of flip-flops updated by one multiply-by-ten
// accumulate per byte, so the sustained rate is one byte per cycle when m_ is not stalled.
// Limits are written on the always-ready cfg_ port (index 0 body limit, index 1 header limit).
module content_length_deframer
    import cld_pkg::*;
#(
    parameter int LENGTH_BITS       = 27,
    parameter int HEADER_COUNT_BITS = 17
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic                    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [7:0]              s_data_byte,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_kind,
    output logic [7:0]                   m_body_byte,
    output logic                         m_last,
    output logic [1:0]                   m_error_code
);

    localparam int LB = LENGTH_BITS;
    localparam int HB = HEADER_COUNT_BITS;
    localparam int CW = (LB > MAX_BODY_W) ? LB : MAX_BODY_W;
    localparam int HW = ((HB + 1) > MAX_HEADER_W) ? (HB + 1) : MAX_HEADER_W;
    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
    localparam logic [HB-1:0] HDR_MAX = {HB{1'b1}};

    logic [MAX_BODY_W-1:0]   max_body_reg;
    logic [MAX_HEADER_W-1:0] max_header_reg;

    logic          in_body_reg, in_body_next;
    logic [LB-1:0] rem_reg, rem_next;
    logic [HB-1:0] hc_reg, hc_next;
    logic [1:0]    term_reg, term_next;
    phase_t        phase_reg, phase_next;
    logic [3:0]    idx_reg, idx_next;
    logic [LB-1:0] acc_reg, acc_next;
    logic          sat_reg, sat_next;
    logic          seen_reg, seen_next;
    logic          inv_reg, inv_next;
    logic          pend_reg, pend_next;

    logic          m_valid_reg;
    logic [1:0]    m_kind_reg;
    logic [7:0]    m_body_byte_reg;
    logic          m_last_reg;
    logic [1:0]    m_error_code_reg;

    logic          res_valid;
    kind_t         res_kind;
    logic [7:0]    res_byte;
    logic          res_last;
    err_t          res_code;

    logic          accept;
    logic          is_digit;
    logic [LB+3:0] acc_ext;
    logic [LB+3:0] prod;
    logic [LB-1:0] acc_digit;
    logic          acc_ovf;
    logic [HB:0]   next_cnt;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_body_byte  = m_body_byte_reg;
    assign m_last       = m_last_reg;
    assign m_error_code = m_error_code_reg;

    // times ten plus digit, saturating
    assign is_digit  = (s_data_byte >= CH_ZERO) && (s_data_byte <= CH_NINE);
    assign acc_ext   = (LB + 4)'(acc_reg);
    assign prod      = (acc_ext << 3) + (acc_ext << 1) + (LB + 4)'(s_data_byte[3:0]);
    assign acc_ovf   = (prod[LB+3:LB] != 4'd0);
    assign acc_digit = acc_ovf ? LEN_MAX : prod[LB-1:0];
    assign next_cnt  = {1'b0, hc_reg} + (HB + 1)'(1);

    always_comb begin
        logic          done;
        logic          clear;
        logic          start_body;
        logic [LB-1:0] body_len;

        in_body_next = in_body_reg;
        rem_next     = rem_reg;
        hc_next      = hc_reg;
        term_next    = term_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        sat_next     = sat_reg;
        seen_next    = seen_reg;
        inv_next     = inv_reg;
        pend_next    = pend_reg;

        res_valid  = 1'b0;
        res_kind   = KIND_BODY;
        res_byte   = 8'd0;
        res_last   = 1'b0;
        res_code   = ERR_HEADER_LONG;
        done       = 1'b0;
        clear      = 1'b0;
        start_body = 1'b0;
        body_len   = acc_reg;

        if (in_body_reg) begin
            res_valid = 1'b1;
            res_byte  = s_data_byte;
            res_last  = (rem_reg <= LB'(1));
            if (rem_reg != '0) begin
                rem_next = rem_reg - LB'(1);
            end
            if (rem_next == '0) begin
                clear = 1'b1;
            end
        end else begin
            hc_next = next_cnt[HB] ? HDR_MAX : next_cnt[HB-1:0];

            // terminator tracking
            if (s_data_byte == CH_CR) begin
                term_next = (term_reg == 2'd2) ? 2'd3 : 2'd1;
            end else if (s_data_byte == CH_LF && (term_reg == 2'd1 || term_reg == 2'd3)) begin
                if (term_reg == 2'd3) begin
                    term_next = 2'd0;
                    done      = 1'b1;
                end else begin
                    term_next = 2'd2;
                end
            end else begin
                term_next = 2'd0;
            end

            // line parser
            if (pend_reg) begin
                pend_next = 1'b0;
                if (s_data_byte == CH_LF) begin
                    if (phase_reg == PH_SPACE) begin
                        inv_next = 1'b1;
                    end
                    if (phase_reg == PH_DIGIT) begin
                        seen_next = 1'b1;
                    end
                    phase_next = PH_PREFIX;
                    idx_next   = 4'd0;
                end else begin
                    // lone cr is a line character that never fits
                    if (phase_reg == PH_SPACE || phase_reg == PH_DIGIT) begin
                        inv_next = 1'b1;
                    end
                    phase_next = PH_SKIP;
                    if (s_data_byte == CH_CR) begin
                        pend_next = 1'b1;
                    end
                end
            end else if (s_data_byte == CH_CR) begin
                pend_next = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_PREFIX: begin
                        if (idx_reg < 4'(PREFIX_LEN) && s_data_byte == prefix_char(idx_reg)) begin
                            idx_next = idx_reg + 4'd1;
                            if (idx_next == 4'(PREFIX_LEN)) begin
                                phase_next = PH_SPACE;
                                acc_next   = '0;
                                sat_next   = 1'b0;
                            end
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SPACE: begin
                        if (s_data_byte != CH_SPACE) begin
                            if (is_digit) begin
                                phase_next = PH_DIGIT;
                                acc_next   = acc_digit;
                                sat_next   = sat_reg | acc_ovf;
                            end else begin
                                inv_next   = 1'b1;
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_DIGIT: begin
                        if (is_digit) begin
                            acc_next = acc_digit;
                            sat_next = sat_reg | acc_ovf;
                        end else begin
                            inv_next   = 1'b1;
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                    end
                    default: begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end

            if (!done) begin
                if (HW'(next_cnt) > HW'(max_header_reg)) begin
                    clear     = 1'b1;
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_code  = ERR_HEADER_LONG;
                end
            end else begin
                clear    = 1'b1;
                body_len = acc_next;
                if (inv_next) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_code  = ERR_INVALID;
                end else if (!seen_next) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_code  = ERR_MISSING;
                end else if (sat_next || CW'(acc_next) > CW'(max_body_reg)) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_code  = ERR_TOO_LARGE;
                end else if (acc_next == '0) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_EMPTY;
                end else begin
                    start_body = 1'b1;
                end
            end
        end

        if (clear) begin
            in_body_next = 1'b0;
            rem_next     = '0;
            hc_next      = '0;
            term_next    = 2'd0;
            phase_next   = PH_PREFIX;
            idx_next     = 4'd0;
            acc_next     = '0;
            sat_next     = 1'b0;
            seen_next    = 1'b0;
            inv_next     = 1'b0;
            pend_next    = 1'b0;
        end
        if (start_body) begin
            in_body_next = 1'b1;
            rem_next     = body_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_body_reg   <= MAX_BODY_RESET;
            max_header_reg <= MAX_HEADER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MAX_BODY:   max_body_reg   <= cfg_data[MAX_BODY_W-1:0];
                REG_MAX_HEADER: max_header_reg <= cfg_data[MAX_HEADER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg <= 1'b0;
            rem_reg     <= '0;
            hc_reg      <= '0;
            term_reg    <= 2'd0;
            phase_reg   <= PH_PREFIX;
            idx_reg     <= 4'd0;
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
            seen_reg    <= 1'b0;
            inv_reg     <= 1'b0;
            pend_reg    <= 1'b0;
        end else if (accept) begin
            in_body_reg <= in_body_next;
            rem_reg     <= rem_next;
            hc_reg      <= hc_next;
            term_reg    <= term_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            acc_reg     <= acc_next;
            sat_reg     <= sat_next;
            seen_reg    <= seen_next;
            inv_reg     <= inv_next;
            pend_reg    <= pend_next;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= accept && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            m_kind_reg       <= res_kind;
            m_body_byte_reg  <= res_byte;
            m_last_reg       <= res_last;
            m_error_code_reg <= res_code;
        end
    end

endmodule

`default_nettype wire

FILE: dv/content_length_deframer_checker.sv
`timescale 1ns / 1ps

module deframe_checker
    import cld_pkg::*;
(
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [cld_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [7:0]                      s_data_byte,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [1:0]                      m_kind,
    input  logic [7:0]                      m_body_byte,
    input  logic                            m_last,
    input  logic [1:0]                      m_error_code,
    input  logic                            draining,
    output int                              fail_count,
    output int                              words_pending,
    output int                              body_words,
    output int                              empty_words,
    output int                              error_words
);

    typedef struct packed {
        kind_t      kind;
        logic [7:0] body_byte;
        logic       last;
        err_t       code;
    } deframe_word_t;

    localparam longint unsigned LEN_CAP = (64'd1 << MAX_BODY_W) - 1;
    localparam longint unsigned HDR_CAP = (64'd1 << MAX_HEADER_W) - 1;
    localparam logic [8*PREFIX_LEN-1:0] LEN_TAG = "Content-Length:";

    logic [MAX_BODY_W-1:0]   body_limit;
    logic [MAX_HEADER_W-1:0] hdr_limit;

    logic                    in_body;
    logic [MAX_BODY_W-1:0]   body_left;
    logic [MAX_HEADER_W-1:0] hdr_count;
    logic [1:0]              crlf_seen;
    phase_t                  phase;
    logic [3:0]              tag_pos;
    logic [MAX_BODY_W-1:0]   len_acc;
    logic                    len_sat;
    logic                    len_seen;
    logic                    len_bad;
    logic                    cr_held;

    deframe_word_t predicted_words[$];
    int            mismatches = 0;
    bit            tail_checked = 1'b0;

    function automatic void clear_parse();
        in_body   = 1'b0;
        body_left = '0;
        hdr_count = '0;
        crlf_seen = '0;
        phase     = PH_PREFIX;
        tag_pos   = '0;
        len_acc   = '0;
        len_sat   = 1'b0;
        len_seen  = 1'b0;
        len_bad   = 1'b0;
        cr_held   = 1'b0;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        logic        is_digit;
        logic [63:0] v;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        case (phase)
            PH_PREFIX: begin
                if (tag_pos < 4'(PREFIX_LEN)
                        && c == LEN_TAG[8*(PREFIX_LEN - 1 - int'(tag_pos)) +: 8]) begin
                    tag_pos = tag_pos + 4'd1;
                    if (tag_pos == 4'(PREFIX_LEN)) begin
                        phase   = PH_SPACE;
                        len_acc = '0;
                        len_sat = 1'b0;
                    end
                end else begin
                    phase = PH_SKIP;
                end
            end
            PH_SPACE, PH_DIGIT: begin
                if (!(phase == PH_SPACE && c == CH_SPACE)) begin
                    if (is_digit) begin
                        phase = PH_DIGIT;
                        v = 64'(len_acc) * 64'd10 + 64'(c - CH_ZERO);
                        if (v > LEN_CAP) begin
                            len_sat = 1'b1;
                            v = LEN_CAP;
                        end
                        len_acc = v[MAX_BODY_W-1:0];
                    end else begin
                        len_bad = 1'b1;
                        phase   = PH_SKIP;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // returns 1 when the byte produces an output word
    function automatic bit deframe_byte(input logic [7:0] c, output deframe_word_t w);
        logic [63:0]           nxt;
        logic [1:0]            p;
        bit                    done;
        bit                    lf_ends_line;
        logic [MAX_BODY_W-1:0] len;
        w.kind      = KIND_BODY;
        w.body_byte = 8'h00;
        w.last      = 1'b0;
        w.code      = ERR_HEADER_LONG;

        if (in_body) begin
            w.body_byte = c;
            w.last      = (body_left <= 1);
            if (body_left > 0)
                body_left = body_left - 1'b1;
            if (body_left == 0)
                clear_parse();
            return 1'b1;
        end

        nxt = 64'(hdr_count) + 64'd1;
        hdr_count = (nxt > HDR_CAP) ? HDR_CAP[MAX_HEADER_W-1:0] : nxt[MAX_HEADER_W-1:0];

        // blank line tracking
        p    = crlf_seen;
        done = 1'b0;
        if (c == CH_CR) begin
            crlf_seen = (p == 2'd2) ? 2'd3 : 2'd1;
        end else if (c == CH_LF && (p == 2'd1 || p == 2'd3)) begin
            done      = (p == 2'd3);
            crlf_seen = done ? 2'd0 : 2'd2;
        end else begin
            crlf_seen = 2'd0;
        end

        // line parsing, a cr only ends a line when lf follows
        lf_ends_line = cr_held && c == CH_LF;
        if (cr_held && c != CH_LF)
            take_char(CH_CR);
        cr_held = 1'b0;
        if (lf_ends_line) begin
            if (phase == PH_SPACE)
                len_bad = 1'b1;
            else if (phase == PH_DIGIT)
                len_seen = 1'b1;
            phase   = PH_PREFIX;
            tag_pos = '0;
        end else if (c == CH_CR) begin
            cr_held = 1'b1;
        end else begin
            take_char(c);
        end

        if (!done) begin
            if (nxt > 64'(hdr_limit)) begin
                clear_parse();
                w.kind = KIND_ERROR;
                return 1'b1;
            end
            return 1'b0;
        end

        w.kind = KIND_ERROR;
        if (len_bad) begin
            w.code = ERR_INVALID;
        end else if (!len_seen) begin
            w.code = ERR_MISSING;
        end else if (len_sat || len_acc > body_limit) begin
            w.code = ERR_TOO_LARGE;
        end else begin
            len = len_acc;
            clear_parse();
            if (len == 0) begin
                w.kind = KIND_EMPTY;
                return 1'b1;
            end
            in_body   = 1'b1;
            body_left = len;
            return 1'b0;
        end
        clear_parse();
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : track
        deframe_word_t want;
        deframe_word_t outcome;
        if (!aresetn) begin
            body_limit = MAX_BODY_RESET;
            hdr_limit  = MAX_HEADER_RESET;
            clear_parse();
            predicted_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MAX_BODY)
                    body_limit = cfg_data[MAX_BODY_W-1:0];
                else
                    hdr_limit = cfg_data[MAX_HEADER_W-1:0];
            end
            if (m_valid && m_ready) begin
                if (predicted_words.size() == 0) begin
                    $display({"%0t unexpected word: expected none, ",
                              "actual kind %0d byte %0h last %0d code %0d"},
                             $time, m_kind, m_body_byte, m_last, m_error_code);
                    mismatches++;
                end else begin
                    want = predicted_words.pop_front();
                    check_field("kind", 8'(want.kind), 8'(m_kind));
                    check_field("body_byte", want.body_byte, m_body_byte);
                    check_field("last", 8'(want.last), 8'(m_last));
                    check_field("error_code", 8'(want.code), 8'(m_error_code));
                    case (want.kind)
                        KIND_BODY:  body_words  <= body_words + 1;
                        KIND_EMPTY: empty_words <= empty_words + 1;
                        default:    error_words <= error_words + 1;
                    endcase
                end
            end
            if (s_valid && s_ready) begin
                if (deframe_byte(s_data_byte, outcome))
                    predicted_words.insert(predicted_words.size(), outcome);
            end
            if (draining && !tail_checked) begin
                tail_checked = 1'b1;
                if (predicted_words.size() != 0) begin
                    want = predicted_words[0];
                    $display({"%0t %0d words never arrived: ",
                              "expected kind %0d code %0d, actual none"},
                             $time, predicted_words.size(), want.kind, want.code);
                    mismatches += predicted_words.size();
                end
            end
        end
        words_pending <= predicted_words.size();
        fail_count    <= mismatches;
    end

endmodule

FILE: dv/content_length_deframer_tb.sv
`timescale 1ns / 1ps

module content_length_deframer_tb;
    import cld_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    reg_index_t             cfg_index = REG_MAX_BODY;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data_byte = 8'h00;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_kind;
    logic [7:0]             m_body_byte;
    logic                   m_last;
    logic [1:0]             m_error_code;

    logic                   draining = 1'b0;
    int                     fail_count;
    int                     words_pending;
    int                     body_words;
    int                     empty_words;
    int                     error_words;

    logic [7:0]             frame[$];
    int                     bytes_sent = 0;
    int                     frames_sent = 0;
    int                     settings_used = 0;
    int                     burst_left = 0;
    int                     body_cap = MAX_BODY_RESET;
    logic [15:0]            ready_mask = 16'hffff;
    int                     ready_pos = 0;
    int                     quiet_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    content_length_deframer i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_body_byte  (m_body_byte),
        .m_last       (m_last),
        .m_error_code (m_error_code)
    );

    deframe_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_body_byte   (m_body_byte),
        .m_last        (m_last),
        .m_error_code  (m_error_code),
        .draining      (draining),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .body_words    (body_words),
        .empty_words   (empty_words),
        .error_words   (error_words)
    );

    // receiver back-pressure
    always @(posedge aclk) begin
        ready_pos <= (ready_pos + 1) % 64;
        if (ready_pos == 63) begin
            case ($urandom_range(0, 3))
                0:       ready_mask <= '1;
                1:       ready_mask <= 16'($urandom);
                default: ready_mask <= 16'($urandom) | 16'($urandom);
            endcase
        end
        m_ready <= ready_mask[ready_pos % 16];
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("%0t no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic void put_byte(input logic [7:0] b);
        frame.insert(frame.size(), b);
    endfunction

    // newline in the text becomes cr lf on the wire
    function automatic void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            if (s[i] == 8'h0a) begin
                put_byte(CH_CR);
                put_byte(CH_LF);
            end else begin
                put_byte(s[i]);
            end
        end
    endfunction

    function automatic void add_filler();
        int n;
        int i;
        case ($urandom_range(0, 7))
            0: add_text("Content-Type: text/plain\n");
            1: add_text("content-length: 12\n");
            2: add_text("Content-Length 7\n");
            3: add_text(" Content-Length: 3\n");
            4: add_text("Content-Lengthx: 1\n");
            5: add_text("X-Id: a\015b\n");
            6: add_text("Content-Len\n");
            default: begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    put_byte(8'($urandom_range(32, 126)));
                add_text("\n");
            end
        endcase
    endfunction

    function automatic void add_length_line(input int len);
        add_text("Content-Length:");
        repeat ($urandom_range(0, 3)) put_byte(CH_SPACE);
        if ($urandom_range(0, 4) == 0)
            add_text("00");
        add_text($sformatf("%0d\n", len));
    endfunction

    function automatic void add_bad_line();
        add_text("Content-Length:");
        case ($urandom_range(0, 9))
            0: add_text("  \n");
            1: add_text("\n");
            2: add_text(" 12 \n");
            3: add_text(" +5\n");
            4: add_text(" -1\n");
            5: add_text(" 7\t\n");
            6: add_text("\t3\n");
            7: add_text(" 4\0155\n");
            8: add_text(" 9\015\015\n");
            default: add_text(" 1a\n");
        endcase
    endfunction

    function automatic void add_huge_line();
        add_text("Content-Length: ");
        if ($urandom_range(0, 1) == 0) begin
            add_text($sformatf("%0d\n", body_cap + $urandom_range(1, 1000)));
        end else begin
            put_byte(8'(CH_ZERO + $urandom_range(1, 9)));
            repeat ($urandom_range(9, 14)) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            add_text("\n");
        end
    endfunction

    function automatic void add_body(input int n);
        repeat (n) begin
            case ($urandom_range(0, 7))
                0:       put_byte(CH_CR);
                1:       put_byte(CH_LF);
                default: put_byte(8'($urandom));
            endcase
        end
    endfunction

    function automatic int pick_length();
        int cap;
        cap = (body_cap < 24) ? body_cap : 24;
        return $urandom_range(0, cap);
    endfunction

    function automatic void make_random_frame();
        int pick;
        int len;
        int keep;
        pick = $urandom_range(0, 99);
        if (pick < 45 || pick >= 90) begin
            len = pick_length();
            repeat ($urandom_range(0, 2)) add_filler();
            add_length_line(len);
            repeat ($urandom_range(0, 1)) add_filler();
            add_text("\n");
            add_body(len);
            // truncated frame runs into the next one
            if (pick >= 90) begin
                keep = $urandom_range(1, frame.size());
                while (frame.size() > keep) frame.pop_back();
            end
        end else if (pick < 55) begin
            case ($urandom_range(0, 2))
                0: add_bad_line();
                1: add_huge_line();
                default: add_length_line($urandom_range(0, 99));
            endcase
            len = pick_length();
            add_length_line(len);
            add_text("\n");
            add_body(len);
        end else if (pick < 65) begin
            repeat ($urandom_range(0, 1)) add_filler();
            add_bad_line();
            repeat ($urandom_range(0, 1)) add_filler();
            add_text("\n");
        end else if (pick < 73) begin
            repeat ($urandom_range(0, 3)) add_filler();
            add_text("\n");
        end else if (pick < 81) begin
            add_huge_line();
            add_text("\n");
        end else begin
            repeat ($urandom_range(1, 16)) put_byte(8'($urandom));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = 1;
                2:       gap = $urandom_range(2, 6);
                default: gap = $urandom_range(7, 24);
            endcase
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 32);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame.size(); i++)
            send_byte(frame[i]);
        bytes_sent += frame.size();
        frames_sent++;
        frame.delete();
    endtask

    // quiet input, all words drained, last byte through the pipe
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limits(input logic [CFG_DATA_W-1:0] body,
                                input logic [CFG_DATA_W-1:0] header);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MAX_BODY;
        cfg_data  <= body;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= REG_MAX_HEADER;
        cfg_data  <= header;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        body_cap = int'(body[MAX_BODY_W-1:0]);
        settings_used++;
    endtask

    task automatic run_random(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            make_random_frame();
            send_frame();
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_limits(MAX_BODY_RESET, CFG_DATA_W'(MAX_HEADER_RESET));
        add_text("Content-Length: 2\n\n");
        put_byte(8'h00);
        put_byte(8'hff);
        add_text("Content-Length:0\n\n");
        add_text("Content-Length: \n\n");
        add_text("Content-Length: 12 \n\n");
        add_text("Host: x\n\n");
        add_text("Content-Length: 67108865\n\n");
        add_text("Content-Length: 999999999999\n\n");
        add_text("Content-Length: x\nContent-Length: 99999999999\n\n");
        add_text("Content-Length: 99999999999\nContent-Length: 1\n\nZ");
        add_text("A\015B\nContent-Length: 1\n\nQ");
        add_text("Content-Length: 1\0152\n\n");
        send_frame();
        settle();

        // body limit equal and one over
        write_limits(27'd3, CFG_DATA_W'(MAX_HEADER_RESET));
        add_text("Content-Length: 3\n\nabcContent-Length: 4\n\n\n\n");
        send_frame();
        settle();

        // header limit of 4, upper bits of the write dropped
        write_limits(27'd0, (27'd1 << 20) | 27'd4);
        add_text("\n\nabcde");
        send_frame();
        settle();

        write_limits(MAX_BODY_RESET, CFG_DATA_W'(MAX_HEADER_RESET));
        run_random(200);
        settle();
        write_limits(27'd0, CFG_DATA_W'(MAX_HEADER_RESET));
        run_random(150);
        settle();
        write_limits(27'd16, 27'd4);
        run_random(100);
        settle();
        write_limits(27'd5, 27'd48);
        run_random(150);
        settle();
        write_limits(CFG_DATA_W'($urandom_range(1, 40)), CFG_DATA_W'($urandom_range(20, 200)));
        run_random(200);
        settle();
        write_limits(MAX_BODY_RESET, CFG_DATA_W'(MAX_HEADER_RESET));
        run_random(200);
        settle();

        draining <= 1'b1;
        repeat (3) @(posedge aclk);
        $display("sent %0d bytes in %0d frames under %0d limit settings",
                 bytes_sent, frames_sent, settings_used);
        $display("checked %0d body bytes, %0d empty messages and %0d errors",
                 body_words, empty_words, error_words);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
